/* rtl/core/ssbu_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the safe-set basis updater
// no dependencies

package ssbu_pkg;

  localparam int COORD_W = 10;
  localparam int FLAT_OUT_W = 19;
  localparam int SIZE_W = 12;
  localparam int ELEM_IDX_W = 11;
  localparam int POINT_W = 3 * COORD_W;

  // request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_FLAG  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DIM0  = 2'd0,
    CFG_DIM1  = 2'd1,
    CFG_DIM2  = 2'd2,
    CFG_THREE = 2'd3
  } cfg_reg_t;

  localparam logic [COORD_W-1:0] DIM0_RST = 10'd376;
  localparam logic [COORD_W-1:0] DIM1_RST = 10'd201;
  localparam logic [COORD_W-1:0] DIM2_RST = 10'd1;

  // one-based grid point, first coordinate in the low bits
  typedef struct packed {
    logic [COORD_W-1:0] c2;
    logic [COORD_W-1:0] c1;
    logic [COORD_W-1:0] c0;
  } point_t;

endpackage

/* rtl/core/ssbu_ram.sv */
`timescale 1ns / 1ps
// generic one-write one-read ram with registered read data
// no dependencies

module ssbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ssbu_flat.sv */
`timescale 1ns / 1ps
// flat cell index of a grid point, four steps over one shared multiplier
// depends on ssbu_pkg

module ssbu_flat #(
  parameter int FLAT_W = 19
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  ssbu_pkg::point_t               pt,
  input  logic [ssbu_pkg::COORD_W-1:0]   dim0,
  input  logic [ssbu_pkg::COORD_W-1:0]   dim1,
  input  logic                           three,
  output logic                           done,
  output logic [FLAT_W-1:0]              flat
);

  typedef enum logic [2:0] {F_IDLE, F_S0, F_S1, F_S2, F_S3} fstate_t;

  fstate_t                             state_r;
  logic [FLAT_W-1:0]                   p_r;
  logic [FLAT_W-1:0]                   acc_r;
  logic                                done_r;
  logic [FLAT_W-1:0]                   mul_a;
  logic [ssbu_pkg::COORD_W-1:0]        mul_b;
  logic [FLAT_W+ssbu_pkg::COORD_W-1:0] prod;

  // coordinates are one-based, offsets wrap modulo the word width
  always_comb begin
    mul_a = FLAT_W'(pt.c1) - FLAT_W'(1);
    mul_b = dim0;
    unique case (state_r)
      F_S1: mul_a = FLAT_W'(pt.c2) - FLAT_W'(1);
      F_S2: begin
        mul_a = p_r;
        mul_b = dim1;
      end
      default: ;
    endcase
  end

  assign prod = (FLAT_W+ssbu_pkg::COORD_W)'(mul_a) * (FLAT_W+ssbu_pkg::COORD_W)'(mul_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        F_IDLE: if (start) begin
          state_r <= F_S0;
        end
        F_S0: begin
          p_r     <= prod[FLAT_W-1:0];
          state_r <= F_S1;
        end
        F_S1: begin
          acc_r   <= FLAT_W'(pt.c0) - FLAT_W'(1) + p_r;
          p_r     <= prod[FLAT_W-1:0];
          state_r <= F_S2;
        end
        F_S2: begin
          p_r     <= prod[FLAT_W-1:0];
          state_r <= F_S3;
        end
        F_S3: begin
          acc_r   <= acc_r + (three ? p_r : '0);
          done_r  <= 1'b1;
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign flat = acc_r;

endmodule

/* rtl/core/safe_set_basis_update.sv */
`timescale 1ns / 1ps
// safe-set basis updater: one sequencer over basis, mark, candidate and seen rams
// depends on ssbu_pkg, ssbu_ram, ssbu_flat
// a read within the set waits on the registered basis ram; a flag without last or an unknown
//   request is answered from idle; start computes the corner index, then sweeps the marks
// round: neighbour generation, compaction, a dominance walk of each candidate over
//   the basis, seen and mark clearing; the walk over the single basis port dominates
// one request at a time, no new request while busy or a result waits untaken
// reset is synchronous; afterwards a clearing pass zeroes the seen map

module safe_set_basis_update #(
  parameter int MAX_ELEMENTS = 2048,
  parameter int MAX_STATES   = 524288,  // power of two
  parameter int MAX_DIMS     = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // elem_index[10:0], unsafe[11], zero pad
  input  logic [1:0]  in_tuser,   // req_type
  input  logic        in_tlast,   // last_flag
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // coord0, coord1, coord2, flat_index, set_size,
                                  // added_count, capacity_hit, zero pad
  output logic        out_tuser,  // round_done
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int CW   = ssbu_pkg::COORD_W;
  localparam int PW   = ssbu_pkg::POINT_W;
  localparam int FOW  = ssbu_pkg::FLAT_OUT_W;
  localparam int IW   = $clog2(MAX_ELEMENTS);
  localparam int NW   = $clog2(MAX_ELEMENTS + 1);
  localparam int SW   = $clog2(MAX_STATES);
  localparam int FLW  = (SW > FOW) ? SW : FOW;
  localparam int NC   = MAX_ELEMENTS * MAX_DIMS;
  localparam int NIW  = $clog2(NC);
  localparam int NCW  = $clog2(NC + 1);
  localparam int BW   = PW + FOW;
  localparam int CDW  = PW + FLW;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_RD_WAIT, S_ST_FLAT,
    S_G_RD, S_G_WAIT, S_G_DIM, S_G_FLAT, S_G_SRD, S_G_SCHK,
    S_C_RD, S_C_WAIT,
    S_D_CRD, S_D_CW, S_D_RD, S_D_CMP,
    S_S_RD, S_S_CLR, S_M_CLR
  } state_t;

  state_t state_r;

  // configuration
  logic [CW-1:0] dim0_r, dim1_r, dim2_r;
  logic          three_r;

  // sequencer registers
  logic [NW-1:0]  cnt_r;      // basis size
  logic [NW-1:0]  idx_r;      // basis walk position
  logic [NW-1:0]  w_r;        // compaction write position
  logic [NW-1:0]  added_r;
  logic           cap_r;
  logic           round_r;
  logic [NCW-1:0] ncand_r;
  logic [NCW-1:0] k_r;
  logic [1:0]     j_r;        // coordinate being lowered
  logic [SW-1:0]  clr_r;
  ssbu_pkg::point_t pt_r;     // flagged element
  logic           mk_r;       // its unsafe mark
  ssbu_pkg::point_t q_r;      // neighbour or candidate
  logic [FLW-1:0] qf_r;
  logic           flat_go_r;

  // result register
  logic           out_valid_r;
  logic [CW-1:0]  o_c0_r, o_c1_r, o_c2_r;
  logic [FOW-1:0] o_flat_r;
  logic [ssbu_pkg::SIZE_W-1:0] o_size_r, o_added_r;
  logic           o_done_r, o_cap_r;

  // ram ports
  logic           b_we, m_we, m_wdata, c_we, s_we, s_wdata;
  logic [IW-1:0]  b_waddr, b_raddr, m_waddr;
  logic [BW-1:0]  b_wdata, b_rd;
  logic           m_rd, s_rd;
  logic [CDW-1:0] c_rd;
  logic [SW-1:0]  s_waddr;

  logic             flat_done;
  logic [FLW-1:0]   flat_res;

  // request decode
  logic                              in_fire;
  ssbu_pkg::req_t                    req;
  logic [ssbu_pkg::ELEM_IDX_W-1:0]   in_idx;
  logic                              in_uns;
  logic                              idx_in_cap, idx_in_set;

  ssbu_pkg::point_t b_pt, c_pt, q_dec;
  logic [CW-1:0]    cj;
  logic             dom;

  assign in_fire    = in_tvalid && in_tready;
  assign req        = ssbu_pkg::req_t'(in_tuser);
  assign in_idx     = in_tdata[10:0];
  assign in_uns     = in_tdata[11];
  assign idx_in_cap = 32'(in_idx) < 32'(MAX_ELEMENTS);
  assign idx_in_set = 32'(in_idx) < 32'(cnt_r);

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  assign b_pt = ssbu_pkg::point_t'(b_rd[BW-1:FOW]);
  assign c_pt = ssbu_pkg::point_t'(c_rd[CDW-1:FLW]);

  // neighbour one lower in coordinate j, third coordinate forced to 0 in 2d
  always_comb begin
    q_dec = pt_r;
    cj    = pt_r.c0;
    unique case (j_r)
      2'd0: begin
        cj       = pt_r.c0;
        q_dec.c0 = pt_r.c0 - CW'(1);
      end
      2'd1: begin
        cj       = pt_r.c1;
        q_dec.c1 = pt_r.c1 - CW'(1);
      end
      default: begin
        cj       = pt_r.c2;
        q_dec.c2 = pt_r.c2 - CW'(1);
      end
    endcase
    if (!three_r) begin
      q_dec.c2 = '0;
    end
  end

  // candidate lies under basis element in every active coordinate
  assign dom = (q_r.c0 <= b_pt.c0) && (q_r.c1 <= b_pt.c1) &&
               (!three_r || (q_r.c2 <= b_pt.c2));

  // ram port steering
  always_comb begin
    b_we    = 1'b0;
    b_waddr = w_r[IW-1:0];
    b_wdata = b_rd;
    b_raddr = idx_r[IW-1:0];
    m_we    = 1'b0;
    m_waddr = idx_r[IW-1:0];
    m_wdata = 1'b0;
    c_we    = 1'b0;
    s_we    = 1'b0;
    s_waddr = qf_r[SW-1:0];
    s_wdata = 1'b0;
    unique case (state_r)
      S_INIT: begin
        s_we    = 1'b1;
        s_waddr = clr_r;
      end
      S_IDLE: begin
        b_raddr = IW'(in_idx);
        if (in_fire && (req == ssbu_pkg::REQ_FLAG) && idx_in_cap) begin
          m_we    = 1'b1;
          m_waddr = IW'(in_idx);
          m_wdata = in_uns;
        end
      end
      S_ST_FLAT: if (flat_done) begin
        b_we    = 1'b1;
        b_waddr = '0;
        b_wdata = {q_r, flat_res[FOW-1:0]};
      end
      S_G_SCHK: if (!s_rd && (32'(ncand_r) < 32'(NC))) begin
        s_we    = 1'b1;
        s_wdata = 1'b1;
        c_we    = 1'b1;
      end
      S_C_WAIT: b_we = !m_rd;
      S_D_RD: if ((idx_r == cnt_r) && (32'(cnt_r) < 32'(MAX_ELEMENTS))) begin
        b_we    = 1'b1;
        b_waddr = cnt_r[IW-1:0];
        b_wdata = {q_r, qf_r[FOW-1:0]};
      end
      S_S_CLR: begin
        s_we    = 1'b1;
        s_waddr = c_rd[SW-1:0];
      end
      S_M_CLR: m_we = 1'b1;
      default: ;
    endcase
  end

  ssbu_ram #(.WIDTH(BW), .DEPTH(MAX_ELEMENTS)) u_basis (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rd)
  );

  ssbu_ram #(.WIDTH(1), .DEPTH(MAX_ELEMENTS)) u_marks (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(idx_r[IW-1:0]), .rdata(m_rd)
  );

  ssbu_ram #(.WIDTH(CDW), .DEPTH(NC)) u_cand (
    .clk(clk), .we(c_we), .waddr(ncand_r[NIW-1:0]), .wdata({q_r, qf_r}),
    .raddr(k_r[NIW-1:0]), .rdata(c_rd)
  );

  ssbu_ram #(.WIDTH(1), .DEPTH(MAX_STATES)) u_seen (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(qf_r[SW-1:0]), .rdata(s_rd)
  );

  ssbu_flat #(.FLAT_W(FLW)) u_flat (
    .clk(clk), .rst_n(rst_n), .start(flat_go_r), .pt(q_r),
    .dim0(dim0_r), .dim1(dim1_r), .three(three_r),
    .done(flat_done), .flat(flat_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      dim0_r      <= ssbu_pkg::DIM0_RST;
      dim1_r      <= ssbu_pkg::DIM1_RST;
      dim2_r      <= ssbu_pkg::DIM2_RST;
      three_r     <= 1'b0;
      cnt_r       <= '0;
      ncand_r     <= '0;
      clr_r       <= '0;
      flat_go_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      flat_go_r <= 1'b0;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (ssbu_pkg::cfg_reg_t'(cfg_index))
          ssbu_pkg::CFG_DIM0:  dim0_r  <= cfg_data;
          ssbu_pkg::CFG_DIM1:  dim1_r  <= cfg_data;
          ssbu_pkg::CFG_DIM2:  dim2_r  <= cfg_data;
          ssbu_pkg::CFG_THREE: three_r <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state_r)
        // seen map zeroing after reset
        S_INIT: begin
          clr_r <= clr_r + SW'(1);
          if (clr_r == SW'(MAX_STATES - 1)) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: if (in_fire) begin
          o_c0_r    <= '0;
          o_c1_r    <= '0;
          o_c2_r    <= '0;
          o_flat_r  <= '0;
          o_size_r  <= ssbu_pkg::SIZE_W'(cnt_r);
          o_added_r <= '0;
          o_done_r  <= 1'b0;
          o_cap_r   <= 1'b0;
          added_r   <= '0;
          cap_r     <= 1'b0;
          round_r   <= 1'b0;
          idx_r     <= '0;
          ncand_r   <= '0;
          unique case (req)
            ssbu_pkg::REQ_START: begin
              q_r.c0    <= dim0_r;
              q_r.c1    <= dim1_r;
              q_r.c2    <= three_r ? dim2_r : '0;
              flat_go_r <= 1'b1;
              state_r   <= S_ST_FLAT;
            end
            ssbu_pkg::REQ_FLAG: begin
              if (in_tlast) begin
                round_r <= 1'b1;
                state_r <= S_G_RD;
              end else begin
                out_valid_r <= 1'b1;
              end
            end
            ssbu_pkg::REQ_READ: begin
              if (idx_in_set) begin
                state_r <= S_RD_WAIT;
              end else begin
                out_valid_r <= 1'b1;
              end
            end
            default: out_valid_r <= 1'b1;
          endcase
        end

        S_RD_WAIT: begin
          o_c0_r      <= b_pt.c0;
          o_c1_r      <= b_pt.c1;
          o_c2_r      <= three_r ? b_pt.c2 : '0;
          o_flat_r    <= b_rd[FOW-1:0];
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end

        // single top corner, then clear the marks
        S_ST_FLAT: if (flat_done) begin
          cnt_r   <= NW'(1);
          idx_r   <= '0;
          state_r <= S_M_CLR;
        end

        // neighbour generation over flagged elements
        S_G_RD: begin
          if (idx_r == cnt_r) begin
            idx_r   <= '0;
            w_r     <= '0;
            state_r <= S_C_RD;
          end else begin
            state_r <= S_G_WAIT;
          end
        end
        S_G_WAIT: begin
          pt_r    <= b_pt;
          mk_r    <= m_rd;
          j_r     <= '0;
          state_r <= S_G_DIM;
        end
        S_G_DIM: begin
          if (!mk_r || (j_r == (three_r ? 2'd3 : 2'd2))) begin
            idx_r   <= idx_r + NW'(1);
            state_r <= S_G_RD;
          end else if (cj > CW'(1)) begin
            q_r       <= q_dec;
            flat_go_r <= 1'b1;
            state_r   <= S_G_FLAT;
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        S_G_FLAT: if (flat_done) begin
          qf_r    <= flat_res;
          state_r <= S_G_SRD;
        end
        S_G_SRD: state_r <= S_G_SCHK;
        S_G_SCHK: begin
          // once the list is full every later neighbour is dropped anyway
          if (!s_rd && (32'(ncand_r) < 32'(NC))) begin
            ncand_r <= ncand_r + NCW'(1);
          end
          j_r     <= j_r + 2'd1;
          state_r <= S_G_DIM;
        end

        // drop flagged elements, order kept
        S_C_RD: begin
          if (idx_r == cnt_r) begin
            cnt_r   <= w_r;
            k_r     <= '0;
            state_r <= S_D_CRD;
          end else begin
            state_r <= S_C_WAIT;
          end
        end
        S_C_WAIT: begin
          if (!m_rd) begin
            w_r <= w_r + NW'(1);
          end
          idx_r   <= idx_r + NW'(1);
          state_r <= S_C_RD;
        end

        // dominance walk and append
        S_D_CRD: begin
          if (k_r == ncand_r) begin
            k_r     <= '0;
            state_r <= S_S_RD;
          end else begin
            state_r <= S_D_CW;
          end
        end
        S_D_CW: begin
          q_r     <= c_pt;
          qf_r    <= c_rd[FLW-1:0];
          idx_r   <= '0;
          state_r <= S_D_RD;
        end
        S_D_RD: begin
          if (idx_r == cnt_r) begin
            if (32'(cnt_r) < 32'(MAX_ELEMENTS)) begin
              cnt_r   <= cnt_r + NW'(1);
              added_r <= added_r + NW'(1);
              k_r     <= k_r + NCW'(1);
              state_r <= S_D_CRD;
            end else begin
              cap_r   <= 1'b1;
              k_r     <= '0;
              state_r <= S_S_RD;
            end
          end else begin
            state_r <= S_D_CMP;
          end
        end
        S_D_CMP: begin
          if (dom) begin
            k_r     <= k_r + NCW'(1);
            state_r <= S_D_CRD;
          end else begin
            idx_r   <= idx_r + NW'(1);
            state_r <= S_D_RD;
          end
        end

        // clear the seen bits this round set
        S_S_RD: begin
          if (k_r == ncand_r) begin
            idx_r   <= '0;
            state_r <= S_M_CLR;
          end else begin
            state_r <= S_S_CLR;
          end
        end
        S_S_CLR: begin
          k_r     <= k_r + NCW'(1);
          state_r <= S_S_RD;
        end

        // mark sweep, then report
        S_M_CLR: begin
          idx_r <= idx_r + NW'(1);
          if (idx_r == NW'(MAX_ELEMENTS - 1)) begin
            o_size_r    <= ssbu_pkg::SIZE_W'(cnt_r);
            o_added_r   <= ssbu_pkg::SIZE_W'(added_r);
            o_done_r    <= round_r;
            o_cap_r     <= cap_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_done_r;
  assign out_tdata  = {6'd0, o_cap_r, o_added_r, o_size_r, o_flat_r, o_c2_r, o_c1_r, o_c0_r};

  // an accepted request always leaves the idle state or yields a result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE) || out_valid_r)
    else $error("request accepted without progress");

  // basis never exceeds its capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(MAX_ELEMENTS))
    else $error("basis count above capacity");

  // candidate list never overflows
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(ncand_r) <= 32'(NC))
    else $error("candidate count above list depth");

  // appended neighbours are part of the basis
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D_CRD) |-> (added_r <= cnt_r))
    else $error("added count above basis size");

  // a round result never reports appends without a round
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_done_r) |-> ((o_added_r == '0) && !o_cap_r))
    else $error("round fields set outside a round");

endmodule
